// ===== hw/rtl/ldsched_pkg.sv =====
// Package for the LOOK disk scheduler: shared widths, register indexes and the
// structs that pass between the top level, the sorting cells and the result stage.
// No dependencies.
`timescale 1ns / 1ps

package ldsched_pkg;

    // Field widths of the item and result ports.
    localparam int CYL_W = 16;
    localparam int SUM_W = 17;

    // Default capacity of the sorting chain.
    localparam int MAX_REQUESTS_DEF = 32;

    // Configuration port geometry.
    localparam int APB_DW = 32;
    localparam int APB_AW = 3;

    // Register indexes, selected by address bit 2.
    localparam logic REG_START_POSITION = 1'b0;
    localparam logic REG_SWEEP_UPWARD   = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [CYL_W-1:0] START_POSITION_RST = '0;
    localparam logic             SWEEP_UPWARD_RST   = 1'b1;

    // Operation broadcast to every cell of the chain.
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_ROT_LEFT,
        OP_ROT_RIGHT
    } t_cell_op;

    typedef struct packed {
        t_cell_op         op;
        logic [CYL_W-1:0] key;
    } t_cell_ctrl;

    // Contents of one cell as seen by its neighbours.
    typedef struct packed {
        logic             valid;
        logic [CYL_W-1:0] value;
    } t_cell_data;

    // One served request handed to the result stage.
    typedef struct packed {
        logic             valid;
        logic [CYL_W-1:0] cyl;
        logic             last;
        logic             dropped;
    } t_emit_req;

endpackage

// ===== hw/rtl/ldsched_cell.sv =====
// One cell of the sorting ring: holds a single request cylinder and its valid bit.
// Inserts in sorted order or rotates one place left or right. Depends on ldsched_pkg.
`timescale 1ns / 1ps

module ldsched_cell (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  ldsched_pkg::t_cell_ctrl i_ctrl,
    input  ldsched_pkg::t_cell_data i_prev,
    input  logic                    i_prev_le,
    input  ldsched_pkg::t_cell_data i_next,
    output ldsched_pkg::t_cell_data o_data,
    output logic                    o_le
);

    logic                           r_valid;
    logic [ldsched_pkg::CYL_W-1:0]  r_value;
    logic                           n_valid;
    logic [ldsched_pkg::CYL_W-1:0]  n_value;

    // This cell keeps its entry on insertion when it already holds a value not above the key.
    assign o_le = r_valid && (r_value <= i_ctrl.key);

    assign o_data.valid = r_valid;
    assign o_data.value = r_value;

    // Next contents: keep, take the new key, or take a neighbour's entry.
    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        case (i_ctrl.op)
            ldsched_pkg::OP_INSERT: begin
                if (!o_le) begin
                    if (i_prev_le) begin
                        n_valid = 1'b1;
                        n_value = i_ctrl.key;
                    end else begin
                        n_valid = i_prev.valid;
                        n_value = i_prev.value;
                    end
                end
            end
            ldsched_pkg::OP_ROT_LEFT: begin
                n_valid = i_next.valid;
                n_value = i_next.value;
            end
            ldsched_pkg::OP_ROT_RIGHT: begin
                n_valid = i_prev.valid;
                n_value = i_prev.value;
            end
            default: begin
                n_valid = r_valid;
                n_value = r_value;
            end
        endcase
    end

    // Valid bit is control state; the value itself needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

// ===== hw/rtl/ldsched_emit.sv =====
// Result stage of the LOOK disk scheduler: tracks the head position and the running
// movement sum, and registers each result item. Depends on ldsched_pkg.
`timescale 1ns / 1ps

module ldsched_emit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_load,
    input  logic [ldsched_pkg::CYL_W-1:0]      i_start_position,
    input  ldsched_pkg::t_emit_req             i_req,
    output logic                               o_result_valid,
    output logic [ldsched_pkg::CYL_W-1:0]      o_served_cylinder,
    output logic [ldsched_pkg::CYL_W-1:0]      o_seek_distance,
    output logic [ldsched_pkg::SUM_W-1:0]      o_total_movement,
    output logic                               o_final_in_order,
    output logic                               o_requests_dropped
);

    logic [ldsched_pkg::CYL_W-1:0] r_head;
    logic [ldsched_pkg::SUM_W-1:0] r_sum;
    logic                          r_valid;
    logic [ldsched_pkg::CYL_W-1:0] n_dist;
    logic [ldsched_pkg::SUM_W-1:0] n_sum;

    // Absolute travel from the current head and the new running total.
    always_comb begin
        if (i_req.cyl >= r_head) begin
            n_dist = i_req.cyl - r_head;
        end else begin
            n_dist = r_head - i_req.cyl;
        end
        n_sum = r_sum + ldsched_pkg::SUM_W'(n_dist);
    end

    // Head and sum are reloaded when a batch goes into service.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= ldsched_pkg::START_POSITION_RST;
            r_sum  <= '0;
        end else if (i_load) begin
            r_head <= i_start_position;
            r_sum  <= '0;
        end else if (i_req.valid) begin
            r_head <= i_req.cyl;
            r_sum  <= n_sum;
        end
    end

    // Result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_req.valid;
        end
    end

    // Result payload registers.
    always_ff @(posedge i_clk) begin
        if (i_req.valid) begin
            o_served_cylinder  <= i_req.cyl;
            o_seek_distance    <= n_dist;
            o_total_movement   <= n_sum;
            o_final_in_order   <= i_req.last;
            o_requests_dropped <= i_req.dropped;
        end
    end

    assign o_result_valid = r_valid;

endmodule

// ===== hw/rtl/look_disk_scheduler.sv =====
// LOOK disk scheduler top level: a ring of sorting cells, a pass sequencer and the result stage.
// Gathering takes one item per cycle; the batch is sorted as it arrives.
// The first result comes from the ring tap once the item marked as batch end is inserted and is
// registered by the result stage, then at most one per cycle, with one rotation pass of the
// ring per direction. start is ignored while busy; the receiver cannot stall results.
// Synchronous reset empties the ring and sets start_position to 0 and sweep_upward to 1.
`timescale 1ns / 1ps

module look_disk_scheduler #(
    parameter int MAX_REQUESTS = ldsched_pkg::MAX_REQUESTS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ldsched_pkg::APB_AW-1:0]     paddr,
    input  logic [ldsched_pkg::APB_DW-1:0]     pwdata,
    output logic [ldsched_pkg::APB_DW-1:0]     prdata,
    output logic                               pready,
    // Item port
    input  logic                               start,
    output logic                               busy,
    input  logic [ldsched_pkg::CYL_W-1:0]      i_request_cylinder,
    input  logic                               i_batch_end,
    // Result port
    output logic                               o_result_valid,
    output logic [ldsched_pkg::CYL_W-1:0]      o_served_cylinder,
    output logic [ldsched_pkg::CYL_W-1:0]      o_seek_distance,
    output logic [ldsched_pkg::SUM_W-1:0]      o_total_movement,
    output logic                               o_final_in_order,
    output logic                               o_requests_dropped
);

    localparam int CNT_W     = $clog2(MAX_REQUESTS + 1);
    localparam int STEP_W    = $clog2(MAX_REQUESTS);
    localparam int LAST_STEP = MAX_REQUESTS - 1;

    typedef enum logic [1:0] {
        S_GATHER,
        S_PASS1,
        S_PASS2
    } t_state;

    t_state                           r_state;
    logic [ldsched_pkg::CYL_W-1:0]    r_start_position;
    logic                             r_sweep_upward;
    logic [CNT_W-1:0]                 r_count;
    logic [CNT_W-1:0]                 r_left;
    logic [STEP_W-1:0]                r_step;
    logic                             r_overflow;

    ldsched_pkg::t_cell_ctrl          w_ctrl;
    ldsched_pkg::t_cell_data          w_data    [MAX_REQUESTS];
    ldsched_pkg::t_cell_data          w_prev    [MAX_REQUESTS];
    ldsched_pkg::t_cell_data          w_next    [MAX_REQUESTS];
    logic                             w_le      [MAX_REQUESTS];
    logic                             w_prev_le [MAX_REQUESTS];
    ldsched_pkg::t_cell_data          w_tap;
    ldsched_pkg::t_emit_req           w_req;
    logic                             w_accept;
    logic                             w_full;
    logic                             w_dir_left;
    logic                             w_upper;
    logic                             w_emit;
    logic                             w_last;
    logic [CNT_W-1:0]                 n_count;

    // Configuration registers and read-back.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_position <= ldsched_pkg::START_POSITION_RST;
            r_sweep_upward   <= ldsched_pkg::SWEEP_UPWARD_RST;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == ldsched_pkg::REG_START_POSITION) begin
                r_start_position <= pwdata[ldsched_pkg::CYL_W-1:0];
            end else begin
                r_sweep_upward <= pwdata[0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == ldsched_pkg::REG_SWEEP_UPWARD) begin
            prdata = {{(ldsched_pkg::APB_DW-1){1'b0}}, r_sweep_upward};
        end else begin
            prdata = {{(ldsched_pkg::APB_DW-ldsched_pkg::CYL_W){1'b0}}, r_start_position};
        end
    end

    // Item acceptance and the insertion count.
    assign busy     = (r_state != S_GATHER);
    assign w_accept = start && !busy;
    assign w_full   = (r_count == CNT_W'(MAX_REQUESTS));
    assign n_count  = w_full ? r_count : r_count + CNT_W'(1);

    // Pass direction: the upper group is served by a left rotation, the lower by a right one.
    assign w_dir_left = (r_state == S_PASS1) ? r_sweep_upward : !r_sweep_upward;
    assign w_tap      = w_dir_left ? w_data[0] : w_data[MAX_REQUESTS-1];
    assign w_upper    = (w_tap.value >= r_start_position);
    assign w_emit     = busy && w_tap.valid && (w_dir_left ? w_upper : !w_upper);
    assign w_last     = w_emit && (r_left == CNT_W'(1));

    // Command broadcast to the ring.
    always_comb begin
        w_ctrl.key = i_request_cylinder;
        if (w_accept && !w_full) begin
            w_ctrl.op = ldsched_pkg::OP_INSERT;
        end else if (busy && w_dir_left) begin
            w_ctrl.op = ldsched_pkg::OP_ROT_LEFT;
        end else if (busy) begin
            w_ctrl.op = ldsched_pkg::OP_ROT_RIGHT;
        end else begin
            w_ctrl.op = ldsched_pkg::OP_HOLD;
        end
    end

    // Ring wiring; an entry that is served at a tap wraps round as empty.
    generate
        for (genvar g = 0; g < MAX_REQUESTS; g++) begin : g_cell
            if (g == 0) begin : g_first
                assign w_prev[g].valid = w_data[MAX_REQUESTS-1].valid && !w_emit;
                assign w_prev[g].value = w_data[MAX_REQUESTS-1].value;
                assign w_prev_le[g]    = 1'b1;
            end else begin : g_inner_prev
                assign w_prev[g]    = w_data[g-1];
                assign w_prev_le[g] = w_le[g-1];
            end
            if (g == MAX_REQUESTS - 1) begin : g_last
                assign w_next[g].valid = w_data[0].valid && !w_emit;
                assign w_next[g].value = w_data[0].value;
            end else begin : g_inner_next
                assign w_next[g] = w_data[g+1];
            end

            ldsched_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctrl    (w_ctrl),
                .i_prev    (w_prev[g]),
                .i_prev_le (w_prev_le[g]),
                .i_next    (w_next[g]),
                .o_data    (w_data[g]),
                .o_le      (w_le[g])
            );
        end
    endgenerate

    // Sequencer: gather, then one rotation pass per group.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_GATHER;
            r_count    <= '0;
            r_left     <= '0;
            r_step     <= '0;
            r_overflow <= 1'b0;
        end else begin
            case (r_state)
                S_GATHER: begin
                    if (w_accept) begin
                        r_count <= n_count;
                        if (w_full) begin
                            r_overflow <= 1'b1;
                        end
                        if (i_batch_end) begin
                            r_left  <= n_count;
                            r_step  <= '0;
                            r_state <= S_PASS1;
                        end
                    end
                end
                S_PASS1, S_PASS2: begin
                    if (w_emit) begin
                        r_left <= r_left - CNT_W'(1);
                    end
                    if (w_last) begin
                        r_count    <= '0;
                        r_overflow <= 1'b0;
                        r_state    <= S_GATHER;
                    end else if (r_state == S_PASS1 && r_step == STEP_W'(LAST_STEP)) begin
                        r_step  <= '0;
                        r_state <= S_PASS2;
                    end else begin
                        r_step <= r_step + STEP_W'(1);
                    end
                end
                default: begin
                    r_state <= S_GATHER;
                end
            endcase
        end
    end

    // Served entry handed to the result stage.
    assign w_req.valid   = w_emit;
    assign w_req.cyl     = w_tap.value;
    assign w_req.last    = w_last;
    assign w_req.dropped = r_overflow;

    ldsched_emit u_emit (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_load             (w_accept && i_batch_end),
        .i_start_position   (r_start_position),
        .i_req              (w_req),
        .o_result_valid     (o_result_valid),
        .o_served_cylinder  (o_served_cylinder),
        .o_seek_distance    (o_seek_distance),
        .o_total_movement   (o_total_movement),
        .o_final_in_order   (o_final_in_order),
        .o_requests_dropped (o_requests_dropped)
    );

endmodule

// ===== sim/look_disk_scheduler_tb.sv =====
// Self-checking testbench for the LOOK disk scheduler: directed batches, then random batches
// under several head positions and sweep directions, each result checked against a predictor.
// Depends on ldsched_pkg and look_disk_scheduler.
`timescale 1ns / 1ps

module look_disk_scheduler_tb;

    localparam int CYL_W        = ldsched_pkg::CYL_W;
    localparam int SUM_W        = ldsched_pkg::SUM_W;
    localparam int APB_AW       = ldsched_pkg::APB_AW;
    localparam int APB_DW       = ldsched_pkg::APB_DW;
    localparam int MAX_REQ      = ldsched_pkg::MAX_REQUESTS_DEF;
    localparam int ITEM_TARGET  = 470;
    localparam int DRAIN_CYCLES = 2 * MAX_REQ + 8;
    localparam int CYCLE_LIMIT  = 400000;

    localparam logic [APB_AW-1:0] ADDR_START_POSITION = {ldsched_pkg::REG_START_POSITION, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_SWEEP_UPWARD   = {ldsched_pkg::REG_SWEEP_UPWARD, 2'b00};

    // One served request as the result port should present it.
    typedef struct {
        logic [CYL_W-1:0] cyl;
        logic [CYL_W-1:0] seek;
        logic [SUM_W-1:0] total;
        logic             is_last;
        logic             dropped;
    } t_service_entry;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [APB_AW-1:0]   paddr = '0;
    logic [APB_DW-1:0]   pwdata = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    logic                start = 1'b0;
    logic                busy;
    logic [CYL_W-1:0]    i_request_cylinder = '0;
    logic                i_batch_end = 1'b0;
    logic                o_result_valid;
    logic [CYL_W-1:0]    o_served_cylinder;
    logic [CYL_W-1:0]    o_seek_distance;
    logic [SUM_W-1:0]    o_total_movement;
    logic                o_final_in_order;
    logic                o_requests_dropped;

    // Predictor state: the batch gathered so far and the registers it will be served with.
    logic [CYL_W-1:0]    pending_cylinders[$];
    logic                batch_overflowed = 1'b0;
    logic [CYL_W-1:0]    head_start = ldsched_pkg::START_POSITION_RST;
    logic                sweep_up = ldsched_pkg::SWEEP_UPWARD_RST;
    t_service_entry      expected_service[$];

    int                  error_count = 0;
    int                  items_sent = 0;
    int                  cycle_count = 0;
    bit                  gaps_on = 1'b1;
    t_service_entry      want;

    look_disk_scheduler #(
        .MAX_REQUESTS(MAX_REQ)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .start              (start),
        .busy               (busy),
        .i_request_cylinder (i_request_cylinder),
        .i_batch_end        (i_batch_end),
        .o_result_valid     (o_result_valid),
        .o_served_cylinder  (o_served_cylinder),
        .o_seek_distance    (o_seek_distance),
        .o_total_movement   (o_total_movement),
        .o_final_in_order   (o_final_in_order),
        .o_requests_dropped (o_requests_dropped)
    );

    always #2 i_clk = ~i_clk;

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     expected_service.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Serve the gathered batch: upper group ascending and lower group descending,
    // in the order that the sweep direction selects, with the head starting at start_position.
    function automatic void serve_batch();
        int             split;
        int             n;
        int             order[$];
        logic [CYL_W-1:0] head;
        logic [CYL_W-1:0] travel;
        logic [SUM_W-1:0] sum;
        t_service_entry entry;
        split = 0;
        n = pending_cylinders.size();
        while (split < n && pending_cylinders[split] < head_start)
            split++;
        if (sweep_up) begin
            for (int i = split; i < n; i++) order.push_back(i);
            for (int i = split - 1; i >= 0; i--) order.push_back(i);
        end else begin
            for (int i = split - 1; i >= 0; i--) order.push_back(i);
            for (int i = split; i < n; i++) order.push_back(i);
        end
        head = head_start;
        sum = '0;
        foreach (order[k]) begin
            entry.cyl = pending_cylinders[order[k]];
            travel = (entry.cyl >= head) ? entry.cyl - head : head - entry.cyl;
            sum = sum + SUM_W'(travel);
            head = entry.cyl;
            entry.seek = travel;
            entry.total = sum;
            entry.is_last = (k == order.size() - 1);
            entry.dropped = batch_overflowed;
            expected_service.push_back(entry);
        end
        pending_cylinders.delete();
        batch_overflowed = 1'b0;
    endfunction

    // Sorted insertion of one accepted request, or an overflow mark when the store is full.
    function automatic void take_request(input logic [CYL_W-1:0] cyl, input logic last);
        int pos;
        pos = 0;
        if (pending_cylinders.size() < MAX_REQ) begin
            while (pos < pending_cylinders.size() && pending_cylinders[pos] <= cyl)
                pos++;
            pending_cylinders.insert(pos, cyl);
        end else begin
            batch_overflowed = 1'b1;
        end
        if (last)
            serve_batch();
    endfunction

    // Offer one item, holding start until the block takes it.
    task automatic send_request(input logic [CYL_W-1:0] cyl, input logic last);
        if (gaps_on && $urandom_range(99) < 24) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_request_cylinder <= cyl;
        i_batch_end <= last;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        take_request(cyl, last);
        items_sent++;
    endtask

    // Stop offering items and let the block finish every batch it holds.
    task automatic drain();
        start <= 1'b0;
        while (expected_service.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One configuration transfer: setup phase, access phase, then a return to idle.
    task automatic apb_transfer(input logic [APB_AW-1:0] addr, input logic wr,
                                input logic [APB_DW-1:0] wdata,
                                output logic [APB_DW-1:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [SUM_W-1:0] expected,
                               input logic [SUM_W-1:0] actual);
        if (actual !== expected) begin
            $display("%0t: %s expected %h got %h", $time, name, expected, actual);
            error_count++;
        end
    endtask

    // Read both registers back and compare with what the predictor holds.
    task automatic check_registers();
        logic [APB_DW-1:0] rdata;
        apb_transfer(ADDR_START_POSITION, 1'b0, '0, rdata);
        check_field("start_position", SUM_W'(head_start), SUM_W'(rdata[CYL_W-1:0]));
        apb_transfer(ADDR_SWEEP_UPWARD, 1'b0, '0, rdata);
        check_field("sweep_upward", SUM_W'(sweep_up), SUM_W'(rdata[0]));
    endtask

    // Write both registers with noise in the unused upper bits, then read them back.
    task automatic set_config(input logic [CYL_W-1:0] pos, input logic up);
        logic [APB_DW-1:0] rdata;
        logic [APB_DW-1:0] noise;
        noise = $urandom;
        apb_transfer(ADDR_START_POSITION, 1'b1, {noise[APB_DW-1:CYL_W], pos}, rdata);
        head_start = pos;
        noise = $urandom;
        apb_transfer(ADDR_SWEEP_UPWARD, 1'b1, {noise[APB_DW-1:1], up}, rdata);
        sweep_up = up;
        check_registers();
    endtask

    // Each result must match the oldest expectation, field by field.
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (expected_service.size() == 0) begin
                $display("%0t: unexpected result, expected none got cylinder %h", $time,
                         o_served_cylinder);
                error_count++;
            end else begin
                want = expected_service.pop_front();
                check_field("served_cylinder", SUM_W'(want.cyl), SUM_W'(o_served_cylinder));
                check_field("seek_distance", SUM_W'(want.seek), SUM_W'(o_seek_distance));
                check_field("total_movement", want.total, o_total_movement);
                check_field("final_in_order", SUM_W'(want.is_last), SUM_W'(o_final_in_order));
                check_field("requests_dropped", SUM_W'(want.dropped),
                            SUM_W'(o_requests_dropped));
            end
        end
    end

    // Registers must come out of reset at their documented values.
    task automatic test_register_reset();
        check_registers();
    endtask

    // A batch of one request under the reset configuration.
    task automatic test_single_request();
        send_request(16'hFFFF, 1'b1);
        drain();
    endtask

    // Both groups present, a request equal to the head position and a duplicate,
    // served in each sweep direction.
    task automatic test_mixed_groups();
        for (int dir = 1; dir >= 0; dir--) begin
            set_config(16'h8000, dir[0]);
            send_request(16'h0000, 1'b0);
            send_request(16'hFFFF, 1'b0);
            send_request(16'h8000, 1'b0);
            send_request(16'h7FFF, 1'b0);
            send_request(16'hFFFF, 1'b1);
            drain();
        end
    endtask

    // Only one group populated: head at the top with upward sweep, head at zero downward.
    task automatic test_one_sided();
        set_config(16'hFFFF, 1'b1);
        send_request(16'h1234, 1'b0);
        send_request(16'hFFFE, 1'b0);
        send_request(16'h0000, 1'b1);
        drain();
        set_config(16'h0000, 1'b0);
        send_request(16'h0001, 1'b0);
        send_request(16'hFFFF, 1'b0);
        send_request(16'h0000, 1'b1);
        drain();
    endtask

    // Random batches under a sequence of settings; some fill the store exactly and some
    // overflow it, so the dropped flag and the dropped final request are both exercised.
    task automatic test_random_batches();
        int               phase;
        int               phase_end;
        int               batch_len;
        int               pick;
        logic [CYL_W-1:0] cyl;
        logic [CYL_W-1:0] prev;
        logic [CYL_W-1:0] pos;
        phase = 0;
        prev = '0;
        while (items_sent < ITEM_TARGET) begin
            case (phase % 4)
                0: pos = 16'h0000;
                1: pos = 16'hFFFF;
                default: pos = CYL_W'($urandom_range(16'hFFFF));
            endcase
            set_config(pos, (phase < 2) ? phase[0] : 1'($urandom_range(1)));
            // The third phase runs without any gaps on the item port.
            gaps_on = (phase != 2);
            phase_end = items_sent + 75;
            while (items_sent < phase_end && items_sent < ITEM_TARGET) begin
                pick = $urandom_range(99);
                if (pick < 10)
                    batch_len = MAX_REQ;
                else if (pick < 20)
                    batch_len = $urandom_range(MAX_REQ + 8, MAX_REQ + 1);
                else
                    batch_len = $urandom_range(12, 1);
                for (int i = 0; i < batch_len; i++) begin
                    case ($urandom_range(5))
                        0: cyl = pos;
                        1: cyl = prev;
                        2: cyl = CYL_W'(pos + $urandom_range(8) - 4);
                        default: cyl = CYL_W'($urandom_range(16'hFFFF));
                    endcase
                    prev = cyl;
                    send_request(cyl, i == batch_len - 1);
                end
            end
            drain();
            phase++;
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_register_reset();
        test_single_request();
        test_mixed_groups();
        test_one_sided();
        test_random_batches();
        drain();
        if (error_count == 0 && expected_service.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
